// File: src/pnp_pkg.sv
// ----------------------------------------------------------------------------
// pnp_pkg
// Widths, constants, sequencer codes and register indexes for the polyline
// nearest-projection block.
// ----------------------------------------------------------------------------
package pnp_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int HEAD_W     = 16;
    localparam int HEAD_FRAC  = 14;
    localparam int MINLEN_W   = 16;
    localparam int IDX_W      = 10;
    localparam int FRAC_W     = 17;
    localparam int DIST_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // path length limit and vertex counter
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int MUL_W  = DIFF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W  = 2 * DIFF_W + 1;
    localparam int Q_BITS = FRAC_W - 1;
    localparam int STEP_W = 4;

    localparam logic [FRAC_W-1:0]        FRAC_ONE   = FRAC_W'(1) << Q_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (Q_BITS - 1);
    localparam logic [STEP_W-1:0]        DIV_LAST   = STEP_W'(Q_BITS - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEHIND_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG_LEN2 = CFG_IDX_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_PROJ = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // steps of the length / dot phase
    localparam logic [STEP_W-1:0] M_LEN_X   = STEP_W'(0);
    localparam logic [STEP_W-1:0] M_LEN_Y   = STEP_W'(1);
    localparam logic [STEP_W-1:0] M_DOT_X   = STEP_W'(2);
    localparam logic [STEP_W-1:0] M_DOT_Y   = STEP_W'(3);
    localparam logic [STEP_W-1:0] M_DOT_SUM = STEP_W'(4);
    localparam logic [STEP_W-1:0] M_DECIDE  = STEP_W'(5);

    // steps of the projection / distance phase
    localparam logic [STEP_W-1:0] P_PX   = STEP_W'(0);
    localparam logic [STEP_W-1:0] P_PY   = STEP_W'(1);
    localparam logic [STEP_W-1:0] P_TX   = STEP_W'(2);
    localparam logic [STEP_W-1:0] P_HX   = STEP_W'(3);
    localparam logic [STEP_W-1:0] P_HY   = STEP_W'(4);
    localparam logic [STEP_W-1:0] P_TXX  = STEP_W'(5);
    localparam logic [STEP_W-1:0] P_TYY  = STEP_W'(6);
    localparam logic [STEP_W-1:0] P_D2   = STEP_W'(7);
    localparam logic [STEP_W-1:0] P_KEEP = STEP_W'(8);

endpackage

// File: src/polyline_nearest_projection.sv
// ----------------------------------------------------------------------------
// polyline_nearest_projection
// Streams path vertices and reports the nearest projection of the vehicle
// onto the polyline, one result per path.
// ----------------------------------------------------------------------------
// Usage: vertices enter on the in_valid/in_ready channel, one per beat. The
// beat marked first_point also carries vehicle position and heading and
// restarts the search. The beat marked last_point produces one result beat on
// out_valid/out_ready; all other beats produce none.
// Registers are written on the cfg channel (cfg_ready is always high); the user
// must write them only while the block is idle, which the block does not enforce.
// Throughput: one vertex at a time. A first point or an unused vertex passes
// straight to the closing state; a segment vertex takes 6 steps of the shared
// 26x26 multiplier for length and dot product, the restoring divider for the
// fraction (skipped when the fraction clamps), up to 9 steps for projected point,
// heading test and distance, then the closing state.
// The result sits in an output register; a stalled receiver only holds the
// block when the next last_point beat needs that register.
// Reset clears the vertex count and the output valid flag and loads the register
// defaults (behind_limit -512 in coordinate units, min_segment_len2 1).
// ----------------------------------------------------------------------------
module polyline_nearest_projection (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [pnp_pkg::COORD_W-1:0]      vehicle_x,
    input  logic signed [pnp_pkg::COORD_W-1:0]      vehicle_y,
    input  logic signed [pnp_pkg::HEAD_W-1:0]       heading_cos,
    input  logic signed [pnp_pkg::HEAD_W-1:0]       heading_sin,
    input  logic signed [pnp_pkg::COORD_W-1:0]      point_x,
    input  logic signed [pnp_pkg::COORD_W-1:0]      point_y,
    input  logic                                    first_point,
    input  logic                                    last_point,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    found,
    output logic [pnp_pkg::IDX_W-1:0]               segment_index,
    output logic [pnp_pkg::FRAC_W-1:0]              segment_fraction,
    output logic signed [pnp_pkg::COORD_W-1:0]      start_x,
    output logic signed [pnp_pkg::COORD_W-1:0]      start_y,
    output logic [pnp_pkg::DIST_W-1:0]              distance_squared,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pnp_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pnp_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import pnp_pkg::*;

    // control
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                last_reg;
    logic                seg_item_reg;
    logic                best_valid_reg;
    logic                out_valid_reg;

    // configuration
    logic signed [CFG_DATA_W-1:0] behind_limit_reg;
    logic [MINLEN_W-1:0]          min_len2_reg;

    // path context
    logic signed [COORD_W-1:0] veh_x_reg, veh_y_reg;
    logic signed [HEAD_W-1:0]  hcos_reg, hsin_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg;

    // segment datapath
    logic signed [DIFF_W-1:0]  abx_reg, aby_reg, apx_reg, apy_reg;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg, len2_reg, dot_reg;
    logic signed [PROD_W-1:0]  sum_w, rnd_w, min_len2_w, limit_w;
    logic signed [COORD_W-1:0] rnd_lo;
    logic [DIV_W-1:0]          rem_reg, rem_sh, rem_next;
    logic                      rem_ge;
    logic [FRAC_W-1:0]         t_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [DIFF_W-1:0]  tx_reg, ty_reg;
    logic [DIST_W-1:0]         d2_reg;

    // best candidate
    logic [DIST_W-1:0]         best_dist_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [FRAC_W-1:0]         best_frac_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg;

    // result register
    logic                      out_found_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic [FRAC_W-1:0]         out_frac_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [DIST_W-1:0]         out_dist_reg;

    logic             in_accept;
    logic             seg_ok;
    logic             behind;
    logic             keep;
    logic             emit;
    logic             done_go;
    logic             dot_nonpos;
    logic [CNT_W-1:0] cnt_eff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign seg_ok = !first_point && (count_reg != '0) && (count_reg < CNT_W'(MAX_POINTS));

    assign sum_w      = acc_reg + prod_reg;
    assign rnd_w      = (prod_reg + ROUND_HALF) >>> Q_BITS;
    assign rnd_lo     = rnd_w[COORD_W-1:0];
    assign min_len2_w = PROD_W'({1'b0, min_len2_reg});
    assign limit_w    = PROD_W'(behind_limit_reg) <<< HEAD_FRAC;

    // sign bit or zero, so the test does not depend on literal signedness
    assign dot_nonpos = dot_reg[PROD_W-1] || (dot_reg == '0);

    // one restoring division step
    assign rem_sh   = {rem_reg[DIV_W-2:0], 1'b0};
    assign rem_ge   = (rem_sh >= len2_reg[DIV_W-1:0]);
    assign rem_next = rem_ge ? (rem_sh - len2_reg[DIV_W-1:0]) : rem_sh;

    // segment 0 is never dropped for lying behind
    assign behind = (count_reg > CNT_W'(1)) && (dot_reg < limit_w);
    assign keep   = !best_valid_reg || (d2_reg < best_dist_reg);

    assign cnt_eff = seg_item_reg ? CNT_W'(count_reg + 1'b1) : count_reg;
    assign done_go = !last_reg || !out_valid_reg || out_ready;
    assign emit    = (state_reg == ST_DONE) && last_reg && done_go;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (step_reg)
                    M_LEN_X:
                    begin
                        mul_a = MUL_W'(abx_reg);
                        mul_b = MUL_W'(abx_reg);
                    end
                    M_LEN_Y:
                    begin
                        mul_a = MUL_W'(aby_reg);
                        mul_b = MUL_W'(aby_reg);
                    end
                    M_DOT_X:
                    begin
                        mul_a = MUL_W'(apx_reg);
                        mul_b = MUL_W'(abx_reg);
                    end
                    M_DOT_Y:
                    begin
                        mul_a = MUL_W'(apy_reg);
                        mul_b = MUL_W'(aby_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_PROJ:
            begin
                case (step_reg)
                    P_PX:
                    begin
                        mul_a = MUL_W'(abx_reg);
                        mul_b = MUL_W'(signed'({1'b0, t_reg}));
                    end
                    P_PY:
                    begin
                        mul_a = MUL_W'(aby_reg);
                        mul_b = MUL_W'(signed'({1'b0, t_reg}));
                    end
                    P_HX:
                    begin
                        mul_a = MUL_W'(tx_reg);
                        mul_b = MUL_W'(hcos_reg);
                    end
                    P_HY:
                    begin
                        mul_a = MUL_W'(ty_reg);
                        mul_b = MUL_W'(hsin_reg);
                    end
                    P_TXX:
                    begin
                        mul_a = MUL_W'(tx_reg);
                        mul_b = MUL_W'(tx_reg);
                    end
                    P_TYY:
                    begin
                        mul_a = MUL_W'(ty_reg);
                        mul_b = MUL_W'(ty_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = seg_ok ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (step_reg == M_DECIDE)
                begin
                    if (len2_reg < min_len2_w)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (dot_nonpos || (dot_reg >= len2_reg))
                    begin
                        state_next = ST_PROJ;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ:
            begin
                if ((step_reg == P_D2 && behind) || step_reg == P_KEEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            count_reg        <= '0;
            last_reg         <= 1'b0;
            seg_item_reg     <= 1'b0;
            best_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            behind_limit_reg <= CFG_DATA_W'(-512);
            min_len2_reg     <= MINLEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;

            if (state_next != state_reg)
            begin
                step_reg <= '0;
            end
            else
            begin
                step_reg <= STEP_W'(step_reg + 1'b1);
            end

            if (in_accept)
            begin
                last_reg     <= last_point;
                seg_item_reg <= seg_ok;
                if (first_point)
                begin
                    count_reg      <= CNT_W'(1);
                    best_valid_reg <= 1'b0;
                end
            end

            if (state_reg == ST_PROJ && step_reg == P_KEEP && keep)
            begin
                best_valid_reg <= 1'b1;
            end

            if (state_reg == ST_DONE && done_go)
            begin
                count_reg <= last_reg ? '0 : cnt_eff;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BEHIND_LIMIT: behind_limit_reg <= cfg_data;
                    REG_MIN_SEG_LEN2: min_len2_reg     <= cfg_data[MINLEN_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_accept)
        begin
            if (first_point)
            begin
                veh_x_reg     <= vehicle_x;
                veh_y_reg     <= vehicle_y;
                hcos_reg      <= heading_cos;
                hsin_reg      <= heading_sin;
                prev_x_reg    <= point_x;
                prev_y_reg    <= point_y;
                best_x_reg    <= point_x;
                best_y_reg    <= point_y;
                best_dist_reg <= '1;
                best_idx_reg  <= '0;
                best_frac_reg <= '0;
            end
            pt_x_reg <= point_x;
            pt_y_reg <= point_y;
            abx_reg  <= DIFF_W'(point_x) - DIFF_W'(prev_x_reg);
            aby_reg  <= DIFF_W'(point_y) - DIFF_W'(prev_y_reg);
            apx_reg  <= DIFF_W'(veh_x_reg) - DIFF_W'(prev_x_reg);
            apy_reg  <= DIFF_W'(veh_y_reg) - DIFF_W'(prev_y_reg);
        end

        case (state_reg)
            ST_MUL:
            begin
                case (step_reg)
                    M_LEN_Y:   acc_reg  <= prod_reg;
                    M_DOT_X:   len2_reg <= sum_w;
                    M_DOT_Y:   acc_reg  <= prod_reg;
                    M_DOT_SUM: dot_reg  <= sum_w;
                    M_DECIDE:
                    begin
                        rem_reg <= dot_reg[DIV_W-1:0];
                        // clamp the fraction at the segment ends
                        if (dot_nonpos)
                        begin
                            t_reg <= '0;
                        end
                        else if (dot_reg >= len2_reg)
                        begin
                            t_reg <= FRAC_ONE;
                        end
                        else
                        begin
                            t_reg <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                t_reg   <= {t_reg[FRAC_W-2:0], rem_ge};
            end
            ST_PROJ:
            begin
                case (step_reg)
                    P_PY: px_reg <= prev_x_reg + rnd_lo;
                    P_TX:
                    begin
                        py_reg <= prev_y_reg + rnd_lo;
                        tx_reg <= DIFF_W'(px_reg) - DIFF_W'(veh_x_reg);
                    end
                    P_HX: ty_reg  <= DIFF_W'(py_reg) - DIFF_W'(veh_y_reg);
                    P_HY: acc_reg <= prod_reg;
                    P_TXX: dot_reg <= sum_w;
                    P_TYY: acc_reg <= prod_reg;
                    P_D2:
                    begin
                        // saturate the squared distance
                        if (sum_w[PROD_W-1:DIST_W] != '0)
                        begin
                            d2_reg <= '1;
                        end
                        else
                        begin
                            d2_reg <= sum_w[DIST_W-1:0];
                        end
                    end
                    P_KEEP:
                    begin
                        if (keep)
                        begin
                            best_dist_reg <= d2_reg;
                            best_idx_reg  <= IDX_W'(count_reg - CNT_W'(1));
                            best_frac_reg <= t_reg;
                            best_x_reg    <= px_reg;
                            best_y_reg    <= py_reg;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DONE:
            begin
                if (seg_item_reg)
                begin
                    prev_x_reg <= pt_x_reg;
                    prev_y_reg <= pt_y_reg;
                end
            end
            default: ;
        endcase

        if (emit)
        begin
            if (cnt_eff >= CNT_W'(2))
            begin
                out_found_reg <= 1'b1;
                out_idx_reg   <= best_idx_reg;
                out_frac_reg  <= best_frac_reg;
                out_x_reg     <= best_x_reg;
                out_y_reg     <= best_y_reg;
                out_dist_reg  <= best_dist_reg;
            end
            else
            begin
                out_found_reg <= 1'b0;
                out_idx_reg   <= '0;
                out_frac_reg  <= '0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_dist_reg  <= '1;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = out_found_reg;
    assign segment_index    = out_idx_reg;
    assign segment_fraction = out_frac_reg;
    assign start_x          = out_x_reg;
    assign start_y          = out_y_reg;
    assign distance_squared = out_dist_reg;

    // block is busy right after taking a vertex
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high in the cycle after an accepted beat");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_fraction <= FRAC_ONE)
        else $error("segment_fraction above 1.0");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (distance_squared == '1) && (segment_index == '0)
                                && (segment_fraction == '0))
        else $error("empty path result not cleared");

    // quotient bits shift in from below, the top bit stays clear while dividing
    a_div_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> !t_reg[FRAC_W-1])
        else $error("fraction overflow during division");

endmodule
